// ----- rtl/sync_word_frame_deframer_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Each macro uses the clk and rst_n names of the module it is placed in.
`ifndef SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SWFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SWFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SWFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SWFD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/swfd_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfd_pkg
// Shared constants and types of the sync word frame deframer.
// ---------------------------------------------------------------------------
package swfd_pkg;

  // Header store depth and derived widths
  localparam int MAX_HEADER = 64;
  localparam int HDR_AW     = $clog2(MAX_HEADER);
  localparam int POS_W      = ($clog2(MAX_HEADER + 1) > 7) ? $clog2(MAX_HEADER + 1) : 7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_WORD    = 3'd0,
    REG_HEADER_SIZE  = 3'd1,
    REG_FN_OFFSET    = 3'd2,
    REG_LEN_OFFSET   = 3'd3,
    REG_STAMP_OFFSET = 3'd4,
    REG_EXPECTED     = 3'd5
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [31:0]      sync_word;
    logic [POS_W-1:0] eff_header;
    logic [5:0]       fn_offset;
    logic [5:0]       len_offset;
    logic [5:0]       stamp_offset;
    logic [27:0]      expected;
  } cfg_t;

endpackage

// ----- rtl/swfd_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfd_if
// Valid/ready channel interfaces of the deframer: stream in, results out,
// configuration writes.
// ---------------------------------------------------------------------------
interface swfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface swfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        last_of_frame;
  logic [31:0] frame_number;
  logic [63:0] timestamp_us;
  logic [31:0] dropped_before;
  logic [31:0] sync_error_count;
  logic [31:0] drop_count;
  modport source (output valid, output kind, output payload_byte, output last_of_frame,
                  output frame_number, output timestamp_us, output dropped_before,
                  output sync_error_count, output drop_count, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last_of_frame,
                  input frame_number, input timestamp_us, input dropped_before,
                  input sync_error_count, input drop_count, output ready);
endinterface

interface swfd_cfg_if import swfd_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/swfd_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module swfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/swfd_cfg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swfd_cfg
// Configuration registers; clamps the header size to the supported range.
// ---------------------------------------------------------------------------
module swfd_cfg import swfd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  swfd_cfg_if.sink      cfg_if,
  output cfg_t          cfg_o
);

  logic [31:0] sync_word_r;
  logic [6:0]  header_size_r;
  logic [5:0]  fn_offset_r;
  logic [5:0]  len_offset_r;
  logic [5:0]  stamp_offset_r;
  logic [27:0] expected_r;
  logic [POS_W-1:0] hs_ext;

  assign cfg_if.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r    <= '0;
      header_size_r  <= 7'd24;
      fn_offset_r    <= 6'd4;
      len_offset_r   <= 6'd8;
      stamp_offset_r <= 6'd12;
      expected_r     <= 28'd1;
    end else if (cfg_if.valid) begin
      case (reg_idx_t'(cfg_if.index))
        REG_SYNC_WORD:    sync_word_r    <= cfg_if.data;
        REG_HEADER_SIZE:  header_size_r  <= cfg_if.data[6:0];
        REG_FN_OFFSET:    fn_offset_r    <= cfg_if.data[5:0];
        REG_LEN_OFFSET:   len_offset_r   <= cfg_if.data[5:0];
        REG_STAMP_OFFSET: stamp_offset_r <= cfg_if.data[5:0];
        REG_EXPECTED:     expected_r     <= cfg_if.data[27:0];
        default: ;
      endcase
    end
  end

  // Clamp header size to 4..MAX_HEADER
  assign hs_ext = POS_W'(header_size_r);

  always_comb begin
    cfg_o.sync_word    = sync_word_r;
    cfg_o.fn_offset    = fn_offset_r;
    cfg_o.len_offset   = len_offset_r;
    cfg_o.stamp_offset = stamp_offset_r;
    cfg_o.expected     = expected_r;
    if (hs_ext < POS_W'(4)) begin
      cfg_o.eff_header = POS_W'(4);
    end else if (hs_ext > POS_W'(MAX_HEADER)) begin
      cfg_o.eff_header = POS_W'(MAX_HEADER);
    end else begin
      cfg_o.eff_header = hs_ext;
    end
  end

endmodule

// ----- rtl/sync_word_frame_deframer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_word_frame_deframer
// Sync word hunt, header capture and payload pass-through on a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_if takes one stream byte per transaction. out_if gives header results
//   (kind 0: frame number, timestamp, frame gap, counters) and payload results
//   (kind 1: byte, last flag, counters). cfg_if writes registers 0..5 and is
//   always ready; write it only while the stream is idle.
//   Hunting, header and payload bytes are taken one per cycle while no fetch,
//   replay or stalled receiver holds input off; a payload byte shows on
//   out_if the cycle after it is taken. Header bytes land in a header RAM.
//   When a header is complete, its length, frame number and timestamp bytes
//   are fetched one byte a cycle from that RAM (first four from hdr_r), so
//   a complete header holds input off until it is judged. A rejected header
//   replays bytes 1 on, one per cycle from the same sources, into the hunt.
//   The output register decouples the two sides: input is taken while a
//   result waits, as long as it is taken in the same cycle; a stalled receiver
//   holds the result and stops input.
//   Reset (rst_n low, synchronous) restores register defaults, starts a hunt
//   and clears counters; the header RAM needs no clearing.
// ---------------------------------------------------------------------------
`include "sync_word_frame_deframer_macros.svh"

module sync_word_frame_deframer import swfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  swfd_in_if.sink    in_if,
  swfd_out_if.source out_if,
  swfd_cfg_if.sink   cfg_if
);

  typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_LOAD} phase_t;
  typedef enum logic [1:0] {M_RUN, M_FETCH, M_REPLAY} mode_t;

  localparam int FETCH_N = 16;

  cfg_t cfg;

  phase_t           phase_r, phase_nxt;
  mode_t            mode_r, mode_nxt;
  logic [31:0]      window_r, window_nxt;
  logic [31:0]      hdr_r, hdr_nxt;
  logic [POS_W-1:0] fill_r, fill_nxt;
  logic [POS_W-1:0] rp_r, rp_nxt;
  logic [27:0]      left_r, left_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic             discard_r, discard_nxt;
  logic [31:0]      errors_r, errors_nxt;
  logic [31:0]      drops_r, drops_nxt;
  logic [4:0]       fetch_r, fetch_nxt;
  logic             d_v_r;
  logic [3:0]       d_k_r;
  logic             d_ram_r;
  logic [7:0]       d_byte_r;
  logic [FETCH_N-1:0][7:0] fb_r;

  logic             out_valid_r, out_valid_nxt;
  logic             o_kind_r, o_kind_nxt;
  logic [7:0]       o_pb_r, o_pb_nxt;
  logic             o_last_r, o_last_nxt;
  logic [31:0]      o_fn_r, o_fn_nxt;
  logic [63:0]      o_ts_r, o_ts_nxt;
  logic [31:0]      o_gap_r, o_gap_nxt;

  logic             in_acc, feed_en, slot_free;
  logic [7:0]       fb_in, rep_byte;
  logic [31:0]      win_shift;
  logic [POS_W-1:0] hunt_fill;
  logic             complete;
  logic             eval;
  logic [31:0]      f_len, f_fn, f_gap;
  logic [32:0]      drop_sum;
  logic [3:0]       fk;
  logic [5:0]       f_base;
  logic [POS_W-1:0] f_idx;
  logic             ram_we;
  logic [HDR_AW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  swfd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg_o  (cfg)
  );

  // Header store
  swfd_ram #(.WIDTH(8), .DEPTH(MAX_HEADER)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[HDR_AW-1:0]),
    .wdata (fb_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake
  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (mode_r == M_RUN) && slot_free;
  assign in_acc      = in_if.valid && in_if.ready;
  assign feed_en     = in_acc || (mode_r == M_REPLAY);

  // Byte source: stream, or replayed header (first four bytes live in hdr_r)
  assign rep_byte = (rp_r < POS_W'(4)) ? hdr_r[8*rp_r[1:0] +: 8] : ram_rdata;
  assign fb_in    = (mode_r == M_REPLAY) ? rep_byte : in_if.data_byte;
  assign ram_we   = feed_en && (phase_r == PH_HEAD);

  // Field fetch addressing: length, frame number, timestamp bytes
  assign fk = fetch_r[3:0];
  always_comb begin
    if (fk < 4'd4) begin
      f_base = cfg.len_offset;
    end else if (fk < 4'd8) begin
      f_base = cfg.fn_offset;
    end else begin
      f_base = cfg.stamp_offset;
    end
    f_idx = POS_W'(f_base) + POS_W'(fk < 4'd8 ? {2'b00, fk[1:0]} : {1'b0, fk[2:0]});
  end

  assign ram_raddr = (mode_r == M_FETCH) ? f_idx[HDR_AW-1:0] : rp_nxt[HDR_AW-1:0];

  // Fetched fields and header evaluation
  assign eval     = (mode_r == M_FETCH) && (fetch_r == 5'(FETCH_N)) && !d_v_r;
  assign f_len    = fb_r[3:0];
  assign f_fn     = fb_r[7:4];
  assign f_gap    = have_prev_r ? (f_fn - (prev_r + 32'd1)) : 32'd0;
  assign drop_sum = {1'b0, drops_r} + {1'b0, f_gap};
  assign win_shift = {fb_in, window_r[31:8]};
  assign hunt_fill = (fill_r >= POS_W'(4)) ? fill_r : fill_r + POS_W'(1);

  // Next-state logic
  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    window_nxt    = window_r;
    hdr_nxt       = hdr_r;
    fill_nxt      = fill_r;
    rp_nxt        = rp_r;
    left_nxt      = left_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    discard_nxt   = discard_r;
    errors_nxt    = errors_r;
    drops_nxt     = drops_r;
    fetch_nxt     = fetch_r;
    complete      = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    o_kind_nxt    = o_kind_r;
    o_pb_nxt      = o_pb_r;
    o_last_nxt    = o_last_r;
    o_fn_nxt      = o_fn_r;
    o_ts_nxt      = o_ts_r;
    o_gap_nxt     = o_gap_r;

    // One byte through the hunt / header / payload logic
    if (feed_en) begin
      case (phase_r)
        PH_LOAD: begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = 1'b1;
          o_pb_nxt      = fb_in;
          o_last_nxt    = (left_r == 28'd1);
          o_fn_nxt      = '0;
          o_ts_nxt      = '0;
          o_gap_nxt     = '0;
          left_nxt      = left_r - 28'd1;
          if (left_nxt == 28'd0) begin
            phase_nxt   = PH_HUNT;
            window_nxt  = '0;
            fill_nxt    = '0;
            discard_nxt = 1'b0;
          end
        end
        PH_HEAD: begin
          fill_nxt = fill_r + POS_W'(1);
          if (fill_nxt >= cfg.eff_header) begin
            complete = 1'b1;
          end
        end
        default: begin
          if (fill_r >= POS_W'(4) && !discard_r) begin
            discard_nxt = 1'b1;
            if (errors_r != '1) begin
              errors_nxt = errors_r + 32'd1;
            end
          end
          fill_nxt   = hunt_fill;
          window_nxt = win_shift;
          if (hunt_fill >= POS_W'(4) && win_shift == cfg.sync_word) begin
            hdr_nxt     = win_shift;
            fill_nxt    = POS_W'(4);
            discard_nxt = 1'b0;
            phase_nxt   = PH_HEAD;
            if (POS_W'(4) >= cfg.eff_header) begin
              complete = 1'b1;
            end
          end
        end
      endcase
    end

    // Replay sequencing
    if (mode_r == M_REPLAY) begin
      if (rp_r == cfg.eff_header - POS_W'(1)) begin
        mode_nxt = M_RUN;
        rp_nxt   = '0;
      end else begin
        rp_nxt = rp_r + POS_W'(1);
      end
    end else if (complete) begin
      mode_nxt  = M_FETCH;
      fetch_nxt = '0;
    end

    // Field fetch and header decision
    if (mode_r == M_FETCH) begin
      if (fetch_r != 5'(FETCH_N)) begin
        fetch_nxt = fetch_r + 5'd1;
      end
      if (eval) begin
        if (f_len != {4'd0, cfg.expected}) begin
          if (errors_r != '1) begin
            errors_nxt = errors_r + 32'd1;
          end
          phase_nxt   = PH_HUNT;
          window_nxt  = '0;
          fill_nxt    = '0;
          discard_nxt = 1'b0;
          mode_nxt    = M_REPLAY;
          rp_nxt      = POS_W'(1);
        end else begin
          if (have_prev_r) begin
            drops_nxt = drop_sum[32] ? '1 : drop_sum[31:0];
          end
          prev_nxt      = f_fn;
          have_prev_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          o_kind_nxt    = 1'b0;
          o_pb_nxt      = '0;
          o_last_nxt    = 1'b0;
          o_fn_nxt      = f_fn;
          o_ts_nxt      = fb_r[15:8];
          o_gap_nxt     = f_gap;
          left_nxt      = f_len[27:0];
          mode_nxt      = M_RUN;
          if (f_len == 32'd0) begin
            phase_nxt   = PH_HUNT;
            window_nxt  = '0;
            fill_nxt    = '0;
            discard_nxt = 1'b0;
          end else begin
            phase_nxt = PH_LOAD;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      mode_r      <= M_RUN;
      window_r    <= '0;
      fill_r      <= '0;
      rp_r        <= '0;
      left_r      <= '0;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      discard_r   <= 1'b0;
      errors_r    <= '0;
      drops_r     <= '0;
      fetch_r     <= '0;
      d_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      window_r    <= window_nxt;
      fill_r      <= fill_nxt;
      rp_r        <= rp_nxt;
      left_r      <= left_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      discard_r   <= discard_nxt;
      errors_r    <= errors_nxt;
      drops_r     <= drops_nxt;
      fetch_r     <= fetch_nxt;
      d_v_r       <= (mode_r == M_FETCH) && (fetch_r != 5'(FETCH_N));
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: header bytes, fetch pipeline, output fields
  always_ff @(posedge clk) begin
    hdr_r    <= hdr_nxt;
    d_k_r    <= fk;
    d_ram_r  <= (f_idx >= POS_W'(4)) && (f_idx < cfg.eff_header);
    d_byte_r <= (f_idx < POS_W'(4)) ? hdr_r[8*f_idx[1:0] +: 8] : 8'd0;
    if (d_v_r) begin
      fb_r[d_k_r] <= d_ram_r ? ram_rdata : d_byte_r;
    end
    o_kind_r <= o_kind_nxt;
    o_pb_r   <= o_pb_nxt;
    o_last_r <= o_last_nxt;
    o_fn_r   <= o_fn_nxt;
    o_ts_r   <= o_ts_nxt;
    o_gap_r  <= o_gap_nxt;
  end

  // Result channel
  assign out_if.valid            = out_valid_r;
  assign out_if.kind             = o_kind_r;
  assign out_if.payload_byte     = o_pb_r;
  assign out_if.last_of_frame    = o_last_r;
  assign out_if.frame_number     = o_fn_r;
  assign out_if.timestamp_us     = o_ts_r;
  assign out_if.dropped_before   = o_gap_r;
  assign out_if.sync_error_count = errors_r;
  assign out_if.drop_count       = drops_r;

  // Checks
  `SWFD_ASSERT_IMP(a_load_nonzero, phase_r == PH_LOAD, left_r != 28'd0, "payload phase with zero count")
  `SWFD_ASSERT_NXT(a_err_mono, 1'b1, errors_r >= $past(errors_r), "sync error count went down")
  `SWFD_ASSERT_IMP(a_replay_pos, mode_r == M_REPLAY, rp_r < cfg.eff_header, "replay past header end")
  `SWFD_ASSERT_IMP(a_hunt_fill, phase_r == PH_HUNT, fill_r <= POS_W'(4), "hunt window overfilled")

endmodule
